>>> sv/teg_pkg.sv
// Shared types, codes and reset values of the thermal and error clock governor.
package teg_pkg;

    // Command codes of an input word.
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_TEMP  = 3'd1;
    localparam logic [2:0] CMD_GOOD  = 3'd2;
    localparam logic [2:0] CMD_BAD   = 3'd3;
    localparam logic [2:0] CMD_EMPTY = 3'd4;
    localparam logic [2:0] CMD_START = 3'd5;

    // Clock step codes of a result word.
    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_DOWN = 2'd1;
    localparam logic [1:0] STEP_UP   = 2'd2;
    localparam logic [1:0] STEP_SET  = 2'd3;

    // Thermal event codes of a result word.
    localparam logic [1:0] EVT_NONE      = 2'd0;
    localparam logic [1:0] EVT_OVERHEAT  = 2'd1;
    localparam logic [1:0] EVT_CUTOFF    = 2'd2;
    localparam logic [1:0] EVT_RECOVERED = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_OVERHEAT_LEVEL = 3'd0;
    localparam logic [2:0] CFG_CUTOFF_LEVEL   = 3'd1;
    localparam logic [2:0] CFG_CLOCK_FLOOR    = 3'd2;
    localparam logic [2:0] CFG_CLOCK_CEILING  = 3'd3;
    localparam logic [2:0] CFG_CLOCK_DEFAULT  = 3'd4;
    localparam logic [2:0] CFG_GOOD_RUN_START = 3'd5;
    localparam logic [2:0] CFG_GOOD_RUN_LIMIT = 3'd6;
    localparam logic [2:0] CFG_HOLDOFF_TICKS  = 3'd7;

    // Configuration reset values.
    localparam logic [15:0] RST_OVERHEAT_LEVEL = 16'd6400;
    localparam logic [15:0] RST_CUTOFF_LEVEL   = 16'd7680;
    localparam logic [7:0]  RST_CLOCK_FLOOR    = 8'd160;
    localparam logic [7:0]  RST_CLOCK_CEILING  = 8'd220;
    localparam logic [7:0]  RST_CLOCK_DEFAULT  = 8'd200;
    localparam logic [6:0]  RST_GOOD_RUN_START = 7'd6;
    localparam logic [6:0]  RST_GOOD_RUN_LIMIT = 7'd96;
    localparam logic [15:0] RST_HOLDOFF_TICKS  = 16'd50;

    // More empty polls in a row than this request a step-down.
    localparam logic [15:0] EMPTY_POLL_LIMIT = 16'd18000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] temp_value;
        logic        temp_whole_degrees;
    } t_in_word;

    typedef struct packed {
        logic [7:0] clock_mhz;
        logic       set_clock_issued;
        logic [1:0] clock_step;
        logic       core_enabled;
        logic [1:0] thermal_event;
    } t_out_word;

    typedef struct packed {
        logic [15:0] overheat_level;
        logic [15:0] cutoff_level;
        logic [7:0]  clock_floor;
        logic [7:0]  clock_ceiling;
        logic [7:0]  clock_default;
        logic [6:0]  good_run_start;
        logic [6:0]  good_run_limit;
        logic [15:0] holdoff_ticks;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  clock_now;
        logic [15:0] ticks_since_change;
        logic [31:0] share_count;
        logic [31:0] share_at_last_error;
        logic [31:0] error_count;
        logic [6:0]  good_run_target;
        logic [14:0] empty_poll_count;
        logic        overheated;
    } t_state;

endpackage

>>> sv/teg_update.sv
// Next-state and result logic of the governor for one event word.
module teg_update
    import teg_pkg::*;
(
    input  t_cfg      i_cfg,
    input  t_state    i_state,
    input  t_in_word  i_word,
    output t_state    o_state,
    output t_out_word o_result
);

    typedef enum logic [2:0] {
        REQ_NONE,
        REQ_DOWN10,
        REQ_DOWN2,
        REQ_UP2,
        REQ_SET
    } t_req;

    logic [15:0] temp_scaled;
    logic [31:0] share_inc;
    logic [31:0] error_inc;
    logic [31:0] share_eff;
    logic [40:0] error_scaled;
    logic [40:0] share_scaled;
    logic        ratio_hit;
    logic [31:0] good_run;
    logic        run_hit;
    logic [15:0] poll_next;
    logic [7:0]  target_dbl;
    logic [6:0]  target_next;

    t_state     s;
    t_req       req;
    logic       req_thermal;
    logic       req_down;
    logic       blocked;
    logic [7:0] down_amt;
    logic [1:0] evt;
    logic       issued;
    logic [1:0] step;

    assign temp_scaled = i_word.temp_whole_degrees ?
                         {1'b0, i_word.temp_value[7:0], 7'b0} : i_word.temp_value;

    assign share_inc = (i_state.share_count == '1) ? i_state.share_count
                                                    : i_state.share_count + 32'd1;
    assign error_inc = (i_state.error_count == '1) ? i_state.error_count
                                                    : i_state.error_count + 32'd1;

    // Error ratio of 0.75 percent: errors * 400 >= shares * 3.
    assign share_eff    = (share_inc == 32'd0) ? 32'd1 : share_inc;
    assign error_scaled = 41'(error_inc) * 41'd400;
    assign share_scaled = 41'(share_eff) * 41'd3;
    assign ratio_hit    = (error_scaled >= share_scaled);

    assign good_run = (share_inc >= i_state.share_at_last_error) ?
                      share_inc - i_state.share_at_last_error : 32'd0;
    assign run_hit  = (good_run >= {25'b0, i_state.good_run_target});

    assign poll_next = {1'b0, i_state.empty_poll_count} + 16'd1;

    assign target_dbl  = {i_state.good_run_target, 1'b0};
    assign target_next = (target_dbl < {1'b0, i_cfg.good_run_limit}) ?
                         target_dbl[6:0] : i_cfg.good_run_limit;

    always_comb begin
        s           = i_state;
        req         = REQ_NONE;
        req_thermal = 1'b0;
        evt         = EVT_NONE;
        issued      = 1'b0;
        step        = STEP_NONE;
        req_down    = 1'b0;
        blocked     = 1'b0;
        down_amt    = 8'd2;

        case (i_word.cmd)
            CMD_TICK: begin
                if (i_state.ticks_since_change != 16'hFFFF) begin
                    s.ticks_since_change = i_state.ticks_since_change + 16'd1;
                end
            end
            CMD_TEMP: begin
                if (i_state.overheated) begin
                    if (temp_scaled < i_cfg.overheat_level) begin
                        s.overheated = 1'b0;
                        evt          = EVT_RECOVERED;
                    end
                end else if (temp_scaled >= i_cfg.overheat_level) begin
                    req_thermal = 1'b1;
                    if (temp_scaled >= i_cfg.cutoff_level) begin
                        req          = REQ_DOWN10;
                        s.overheated = 1'b1;
                        evt          = EVT_CUTOFF;
                    end else begin
                        req = REQ_DOWN2;
                        evt = EVT_OVERHEAT;
                    end
                end
            end
            CMD_GOOD: begin
                if (!i_state.overheated) begin
                    s.share_count      = share_inc;
                    s.empty_poll_count = '0;
                    if (run_hit) begin
                        req = REQ_UP2;
                    end
                end
            end
            CMD_BAD: begin
                if (!i_state.overheated) begin
                    s.share_count         = share_inc;
                    s.empty_poll_count    = '0;
                    s.error_count         = error_inc;
                    s.share_at_last_error = share_inc;
                    if ((i_state.clock_now > i_cfg.clock_default || error_inc > 32'd1)
                        && ratio_hit) begin
                        req = REQ_DOWN2;
                    end
                end
            end
            CMD_EMPTY: begin
                if (!i_state.overheated) begin
                    if (poll_next > EMPTY_POLL_LIMIT) begin
                        s.empty_poll_count = '0;
                        req                = REQ_DOWN2;
                    end else if (poll_next > 16'h7FFF) begin
                        s.empty_poll_count = 15'h7FFF;
                    end else begin
                        s.empty_poll_count = poll_next[14:0];
                    end
                end
            end
            CMD_START: begin
                s.clock_now = i_cfg.clock_default;
                req         = REQ_SET;
            end
            default: begin
            end
        endcase

        // Rate-limited clock change. Passing the holdoff restarts the tick, share and
        // error counters even when the floor or ceiling then refuses the step.
        req_down = (req == REQ_DOWN10) || (req == REQ_DOWN2);
        down_amt = (req == REQ_DOWN10) ? 8'd10 : 8'd2;
        if (req != REQ_NONE && i_state.ticks_since_change >= i_cfg.holdoff_ticks) begin
            s.ticks_since_change  = '0;
            s.share_count         = '0;
            s.share_at_last_error = '0;
            s.error_count         = '0;
            blocked = (!req_thermal && req_down && s.clock_now <= i_cfg.clock_floor)
                   || (req == REQ_UP2 && s.clock_now >= i_cfg.clock_ceiling);
            if (!blocked) begin
                issued = 1'b1;
                if (req_down) begin
                    s.good_run_target = target_next;
                    s.clock_now = (s.clock_now > down_amt) ? s.clock_now - down_amt
                                                           : 8'd0;
                    step = STEP_DOWN;
                end else if (req == REQ_UP2) begin
                    s.clock_now = (s.clock_now >= 8'd253) ? 8'd255
                                                          : s.clock_now + 8'd2;
                    step = STEP_UP;
                end else begin
                    step = STEP_SET;
                end
            end
        end
    end

    assign o_state                   = s;
    assign o_result.clock_mhz        = s.clock_now;
    assign o_result.set_clock_issued = issued;
    assign o_result.clock_step       = step;
    assign o_result.core_enabled     = ~s.overheated;
    assign o_result.thermal_event    = evt;

endmodule

>>> sv/thermal_error_clock_governor.sv
// Top level of the thermal and error driven clock governor.
//
// Event words (tick, temperature, good result, bad result, empty poll, start)
// enter on the input channel: a word is taken at a rising edge where
// i_in_valid is high and o_in_stall is low. Each word yields exactly one
// result word on the output channel, taken where o_out_valid is high and
// i_out_stall is low. The result carries the clock after the event, whether a
// set-clock command went out and which way, the core enable and any thermal
// event.
// The word lands in the input register at the accepting edge; from there
// the governor state and the result register are updated together by a
// single pass of update logic. While no waiting result is stalled, a new
// word is taken every cycle, so the throughput is one word per clock.
// When the receiver stalls while a result waits, the whole two-stage pipe
// holds and o_in_stall rises in the same cycle; nothing is dropped.
// Configuration registers are written through the cfg channel, which is
// always ready; they are meant to change only while the pipe is empty.
// Synchronous reset loads the register defaults, sets the clock to its
// default value, clears the counters and the overheat flag, and saturates
// the holdoff count so that the first clock change is allowed.
module thermal_error_clock_governor
    import teg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;
    logic      advance;

    // The pipe moves whenever the result register is free or being taken.
    assign advance     = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    teg_update u_update (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_word   (r_in_word),
        .o_state  (n_state),
        .o_result (n_out_word)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overheat_level <= RST_OVERHEAT_LEVEL;
            r_cfg.cutoff_level   <= RST_CUTOFF_LEVEL;
            r_cfg.clock_floor    <= RST_CLOCK_FLOOR;
            r_cfg.clock_ceiling  <= RST_CLOCK_CEILING;
            r_cfg.clock_default  <= RST_CLOCK_DEFAULT;
            r_cfg.good_run_start <= RST_GOOD_RUN_START;
            r_cfg.good_run_limit <= RST_GOOD_RUN_LIMIT;
            r_cfg.holdoff_ticks  <= RST_HOLDOFF_TICKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OVERHEAT_LEVEL: r_cfg.overheat_level <= i_cfg_data;
                CFG_CUTOFF_LEVEL:   r_cfg.cutoff_level   <= i_cfg_data;
                CFG_CLOCK_FLOOR:    r_cfg.clock_floor    <= i_cfg_data[7:0];
                CFG_CLOCK_CEILING:  r_cfg.clock_ceiling  <= i_cfg_data[7:0];
                CFG_CLOCK_DEFAULT:  r_cfg.clock_default  <= i_cfg_data[7:0];
                CFG_GOOD_RUN_START: r_cfg.good_run_start <= i_cfg_data[6:0];
                CFG_GOOD_RUN_LIMIT: r_cfg.good_run_limit <= i_cfg_data[6:0];
                CFG_HOLDOFF_TICKS:  r_cfg.holdoff_ticks  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Governor state. The reset target uses the reset value of good_run_start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.clock_now           <= RST_CLOCK_DEFAULT;
            r_state.ticks_since_change  <= 16'hFFFF;
            r_state.share_count         <= '0;
            r_state.share_at_last_error <= '0;
            r_state.error_count         <= '0;
            r_state.good_run_target     <= RST_GOOD_RUN_START;
            r_state.empty_poll_count    <= '0;
            r_state.overheated          <= 1'b0;
        end else if (advance && r_in_valid) begin
            r_state <= n_state;
        end
    end

    // Input register and result register, moving together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid  <= i_in_valid;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (advance && r_in_valid) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
